### design/pfs_pkg.sv
// Shared types, constants and pattern tables for the PEM private frame scanner.
`timescale 1ns / 1ps
`default_nettype none

package pfs_pkg;

    // Pattern lengths
    localparam logic [3:0] BEGIN_LEN = 4'd11;
    localparam logic [3:0] PRIV_LEN  = 4'd11;
    localparam logic [2:0] DASH_LEN  = 3'd5;

    // Characters with special roles
    localparam logic [7:0] CHAR_DASH = 8'h2D;
    localparam logic [7:0] CHAR_P    = 8'h50;

    // One accepted input item
    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } pfs_item_t;

    // Scanner state
    typedef struct packed {
        logic       in_label;
        logic [3:0] begin_progress;
        logic [3:0] private_progress;
        logic       private_seen;
        logic [2:0] dash_run;
        logic       found_flag;
    } pfs_state_t;

    // Output stage handshake status
    typedef struct packed {
        logic load;
        logic found;
    } pfs_result_t;

    // "-----BEGIN " by position
    function automatic logic [7:0] begin_char(input logic [3:0] k);
        logic [7:0] c;
        case (k)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4: c = CHAR_DASH;
            4'd5:    c = 8'h42; // B
            4'd6:    c = 8'h45; // E
            4'd7:    c = 8'h47; // G
            4'd8:    c = 8'h49; // I
            4'd9:    c = 8'h4E; // N
            4'd10:   c = 8'h20; // space
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "PRIVATE KEY" by position
    function automatic logic [7:0] priv_char(input logic [3:0] k);
        logic [7:0] c;
        case (k)
            4'd0:    c = CHAR_P;
            4'd1:    c = 8'h52; // R
            4'd2:    c = 8'h49; // I
            4'd3:    c = 8'h56; // V
            4'd4:    c = 8'h41; // A
            4'd5:    c = 8'h54; // T
            4'd6:    c = 8'h45; // E
            4'd7:    c = 8'h20; // space
            4'd8:    c = 8'h4B; // K
            4'd9:    c = 8'h45; // E
            4'd10:   c = 8'h59; // Y
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### design/pfs_in_stage.sv
// Input register stage: holds one byte transfer until the scanner takes it.
`timescale 1ns / 1ps
`default_nettype none

module pfs_in_stage
    import pfs_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire pfs_item_t in_item,
    output logic           item_valid,
    output pfs_item_t      item,
    input  wire logic      item_take
);

    logic      valid_reg;
    logic      valid_next;
    pfs_item_t item_reg;

    // Free when empty or when the held byte leaves this cycle
    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (item_take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

### design/pfs_scan_core.sv
// Marker and label matching state with its one-byte next-state logic.
`timescale 1ns / 1ps
`default_nettype none

module pfs_scan_core
    import pfs_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      step,
    input  wire pfs_item_t item,
    output pfs_result_t    result
);

    pfs_state_t state_reg;
    pfs_state_t state_next;
    pfs_state_t scan;
    logic [3:0] pp_next;
    logic       is_dash;

    assign is_dash = (item.text_byte == CHAR_DASH);

    // Match one byte against the current state
    always_comb begin
        scan    = state_reg;
        pp_next = 4'd0;
        if (!state_reg.in_label) begin
            // Opening marker search, dash runs fall back to five dashes
            if (state_reg.begin_progress < BEGIN_LEN &&
                item.text_byte == begin_char(state_reg.begin_progress)) begin
                scan.begin_progress = state_reg.begin_progress + 4'd1;
            end else if (is_dash) begin
                if (state_reg.begin_progress == {1'b0, DASH_LEN}) begin
                    scan.begin_progress = {1'b0, DASH_LEN};
                end else if (state_reg.begin_progress > {1'b0, DASH_LEN}) begin
                    scan.begin_progress = 4'd1;
                end else begin
                    scan.begin_progress = state_reg.begin_progress + 4'd1;
                end
            end else begin
                scan.begin_progress = 4'd0;
            end
            if (scan.begin_progress >= BEGIN_LEN) begin
                scan.in_label         = 1'b1;
                scan.begin_progress   = 4'd0;
                scan.private_progress = 4'd0;
                scan.private_seen     = 1'b0;
                scan.dash_run         = 3'd0;
            end
        end else begin
            // Label body: look for the private key words
            if (state_reg.private_progress < PRIV_LEN &&
                item.text_byte == priv_char(state_reg.private_progress)) begin
                pp_next = state_reg.private_progress + 4'd1;
            end else if (item.text_byte == CHAR_P) begin
                pp_next = 4'd1;
            end
            scan.private_progress = pp_next;
            if (pp_next >= PRIV_LEN) begin
                scan.private_seen     = 1'b1;
                scan.private_progress = 4'd0;
            end
            // Five dashes close the label
            if (is_dash) begin
                scan.dash_run = state_reg.dash_run + 3'd1;
                if (scan.dash_run >= DASH_LEN) begin
                    scan.found_flag       = state_reg.found_flag | scan.private_seen;
                    scan.in_label         = 1'b0;
                    scan.begin_progress   = 4'd0;
                    scan.private_progress = 4'd0;
                    scan.private_seen     = 1'b0;
                    scan.dash_run         = 3'd0;
                end
            end else begin
                scan.dash_run = 3'd0;
            end
        end
    end

    // End of text starts a fresh scan
    always_comb begin
        state_next = state_reg;
        if (step) begin
            state_next = item.last_byte ? '0 : scan;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else begin
            state_reg <= state_next;
        end
    end

    assign result.load  = step && item.last_byte;
    assign result.found = scan.found_flag;

endmodule

`default_nettype wire

### design/pfs_out_stage.sv
// Result register: holds the found flag until the master side takes it.
`timescale 1ns / 1ps
`default_nettype none

module pfs_out_stage
    import pfs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire pfs_result_t result,
    output logic             slot_free,
    output logic             out_valid,
    output logic             out_found,
    input  wire logic        out_ready
);

    logic valid_reg;
    logic valid_next;
    logic found_reg;

    assign slot_free  = !valid_reg || out_ready;
    assign valid_next = result.load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.load) begin
            found_reg <= result.found;
        end
    end

    assign out_valid = valid_reg;
    assign out_found = found_reg;

endmodule

`default_nettype wire

### design/pem_private_frame_scanner.sv
// PEM private frame scanner top level: input register, scanner, result register.
// A final byte passes from the input register through the scanner, and its result is held in the result register.
// Throughput: one byte per cycle while no final byte waits; the scanner state updates once per byte.
// A final byte waits in the input register while an earlier result is untaken.
// Reset (aresetn low, synchronous) empties both registers and clears the scan state.
`timescale 1ns / 1ps
`default_nettype none

module pem_private_frame_scanner
    import pfs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,  // [7:0] text_byte
    input  wire logic       s_axis_tlast,  // last_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata   // [0] private_found, [7:1] zero
);

    pfs_item_t   in_item;
    pfs_item_t   item;
    logic        item_valid;
    logic        item_take;
    logic        slot_free;
    logic        out_found;
    pfs_result_t result;

    assign in_item.text_byte = s_axis_tdata;
    assign in_item.last_byte = s_axis_tlast;

    // A final byte needs room in the result register
    assign item_take = item_valid && (!item.last_byte || slot_free);

    pfs_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    pfs_scan_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (item_take),
        .item    (item),
        .result  (result)
    );

    pfs_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .result    (result),
        .slot_free (slot_free),
        .out_valid (m_axis_tvalid),
        .out_found (out_found),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {7'd0, out_found};

endmodule

`default_nettype wire
